// ----- src/dcrc_pkg.sv -----
package dcrc_pkg;

  // field widths
  localparam int unsigned WordW   = 32;
  localparam int unsigned RadixW  = 4;
  localparam int unsigned CountW  = 16;
  localparam int unsigned DigitW  = 4;

  // digit budget and its counter width
  localparam int unsigned MaxDigits = 10;
  localparam int unsigned NCntW     = $clog2(MaxDigits + 1);

  // accepted base range
  localparam logic [RadixW-1:0] RadixMin = RadixW'(2);
  localparam logic [RadixW-1:0] RadixMax = RadixW'(9);

  // packed stream widths, padded to whole bytes
  localparam int unsigned InBits   = WordW + RadixW;
  localparam int unsigned InDataW  = ((InBits + 7) / 8) * 8;
  localparam int unsigned OutBits  = 2 + 2 * WordW + 2 * CountW;
  localparam int unsigned OutDataW = ((OutBits + 7) / 8) * 8;

  localparam logic [CountW-1:0] CountTop = '1;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_BASE  = 2'd1,
    ST_BAD_DIGIT = 2'd2
  } dcrc_status_e;

  // digit unit sequencer
  typedef enum logic [1:0] {
    U_IDLE,
    U_RUN,
    U_DONE
  } dcrc_unit_state_e;

  // top level control
  typedef enum logic {
    T_IDLE,
    T_BUSY
  } dcrc_top_state_e;

  // conversion result handed from the digit unit to the top level
  typedef struct packed {
    logic               done;
    dcrc_status_e       status;
    logic [WordW-1:0]   value;
  } dcrc_result_t;

endpackage

// ----- src/dcrc_digit_unit.sv -----
module dcrc_digit_unit
  import dcrc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [WordW-1:0]  word_i,
  input  logic [RadixW-1:0] radix_i,
  input  logic              take_i,
  output dcrc_result_t      result_o
);

  // 2^35 / 10 rounded up: exact quotient for any 32-bit dividend
  localparam logic [WordW-1:0] Recip10 = 32'hCCCC_CCCD;
  localparam int unsigned      RecipSh = 35;

  dcrc_unit_state_e state_q, state_d;

  logic [WordW-1:0]  rest_q, rest_d;
  logic [DigitW-1:0] digit_q, digit_d;
  logic              dvalid_q, dvalid_d;
  logic [NCntW-1:0]  n_q, n_d;
  logic              neg_q, neg_d;
  logic [RadixW-1:0] base_q, base_d;
  logic [WordW-1:0]  acc_q, acc_d;
  logic [WordW-1:0]  weight_q, weight_d;
  dcrc_status_e      status_q, status_d;

  logic [2*WordW-1:0] prod;
  logic [WordW-1:0]   quot;
  logic [WordW-1:0]   remw;
  logic               base_bad;
  logic               digit_bad;
  logic               extract;
  logic               finish;
  logic [WordW-1:0]   mag_in;

  // divide by ten through the reciprocal, remainder by shift and subtract
  assign prod = rest_q * Recip10;
  assign quot = WordW'(prod[2*WordW-1:RecipSh]);
  assign remw = rest_q - (quot << 3) - (quot << 1);

  assign base_bad  = (radix_i < RadixMin) || (radix_i > RadixMax);
  assign digit_bad = dvalid_q && (digit_q >= base_q);
  assign extract   = (rest_q != '0) && (n_q < NCntW'(MaxDigits)) && !digit_bad;
  assign finish    = digit_bad || (!extract && !dvalid_q);
  assign mag_in    = word_i[WordW-1] ? (WordW'(0) - word_i) : word_i;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      U_IDLE: begin
        if (start_i) begin
          state_d = base_bad ? U_DONE : U_RUN;
        end
      end
      U_RUN: begin
        if (finish) begin
          state_d = U_DONE;
        end
      end
      U_DONE: begin
        if (take_i) begin
          state_d = U_IDLE;
        end
      end
      default: state_d = U_IDLE;
    endcase
  end

  // shared digit step: extract one digit while the previous one is weighed in
  always_comb begin
    rest_d   = rest_q;
    digit_d  = digit_q;
    dvalid_d = dvalid_q;
    n_d      = n_q;
    neg_d    = neg_q;
    base_d   = base_q;
    acc_d    = acc_q;
    weight_d = weight_q;
    status_d = status_q;
    case (state_q)
      U_IDLE: begin
        if (start_i) begin
          rest_d   = mag_in;
          dvalid_d = 1'b0;
          n_d      = '0;
          neg_d    = word_i[WordW-1];
          base_d   = radix_i;
          acc_d    = '0;
          weight_d = WordW'(1);
          status_d = base_bad ? ST_BAD_BASE : ST_OK;
        end
      end
      U_RUN: begin
        if (extract) begin
          rest_d  = quot;
          digit_d = remw[DigitW-1:0];
          n_d     = n_q + NCntW'(1);
        end
        dvalid_d = extract;
        if (digit_bad) begin
          status_d = ST_BAD_DIGIT;
        end else if (dvalid_q) begin
          acc_d    = acc_q + WordW'(digit_q * weight_q);
          weight_d = WordW'(base_q * weight_q);
        end
      end
      default: ;
    endcase
  end

  // result view
  always_comb begin
    result_o.done   = (state_q == U_DONE);
    result_o.status = status_q;
    if (status_q == ST_OK) begin
      result_o.value = neg_q ? (WordW'(0) - acc_q) : acc_q;
    end else begin
      result_o.value = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= U_IDLE;
      dvalid_q <= 1'b0;
      status_q <= ST_OK;
    end else begin
      state_q  <= state_d;
      dvalid_q <= dvalid_d;
      status_q <= status_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    rest_q   <= rest_d;
    digit_q  <= digit_d;
    n_q      <= n_d;
    neg_q    <= neg_d;
    base_q   <= base_d;
    acc_q    <= acc_d;
    weight_q <= weight_d;
  end

endmodule

// ----- src/decimal_coded_radix_converter.sv -----
// channel  | dir | tdata fields, lowest bit first
// s_axis   | in  | coded_number[31:0], radix[35:32], zero pad to 40 bits
// m_axis   | out | status[1:0], converted_value[33:2], largest_value[65:34],
//          |     | largest_position[81:66], items_accepted[97:82], pad to 104
//
// each item runs through the divide-by-ten digit step, which handles one digit
// per cycle
// s_axis_tready is low from accept until the result enters the output register
// and goes high with it; a stalled output keeps the result in the digit unit
// reset clears the largest value, its position and the item count
module decimal_coded_radix_converter
  import dcrc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,   // coded_number, radix
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata    // status, converted_value,
                                              // largest_value, largest_position,
                                              // items_accepted
);

  dcrc_top_state_e state_q, state_d;
  dcrc_result_t    res;

  logic                start;
  logic                slot_free;
  logic                take;
  logic                res_ok;
  logic                new_best;
  logic [CountW-1:0]   count_inc;

  logic [WordW-1:0]    best_q, best_d;
  logic [CountW-1:0]   pos_q, pos_d;
  logic [CountW-1:0]   count_q, count_d;
  logic                mvalid_q, mvalid_d;
  logic [OutDataW-1:0] mdata_q;

  assign s_axis_tready = (state_q == T_IDLE);
  assign start         = s_axis_tvalid && s_axis_tready;
  assign slot_free     = !mvalid_q || m_axis_tready;
  assign take          = (state_q == T_BUSY) && res.done && slot_free;

  dcrc_digit_unit u_digit (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .word_i   (s_axis_tdata[WordW-1:0]),
    .radix_i  (s_axis_tdata[WordW +: RadixW]),
    .take_i   (take),
    .result_o (res)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      T_IDLE: begin
        if (start) begin
          state_d = T_BUSY;
        end
      end
      T_BUSY: begin
        if (take) begin
          state_d = T_IDLE;
        end
      end
      default: state_d = T_IDLE;
    endcase
  end

  // running count and largest value
  assign res_ok    = (res.status == ST_OK);
  assign count_inc = (count_q == CountTop) ? count_q : (count_q + CountW'(1));
  assign new_best  = (pos_q == '0) || ($signed(best_q) < $signed(res.value));

  always_comb begin
    best_d  = best_q;
    pos_d   = pos_q;
    count_d = count_q;
    if (take && res_ok) begin
      count_d = count_inc;
      if (new_best) begin
        best_d = res.value;
        pos_d  = count_inc;
      end
    end
  end

  // output register valid
  always_comb begin
    mvalid_d = mvalid_q;
    if (take) begin
      mvalid_d = 1'b1;
    end else if (m_axis_tready) begin
      mvalid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= T_IDLE;
      best_q   <= '0;
      pos_q    <= '0;
      count_q  <= '0;
      mvalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      best_q   <= best_d;
      pos_q    <= pos_d;
      count_q  <= count_d;
      mvalid_q <= mvalid_d;
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (take) begin
      mdata_q <= OutDataW'({count_d, pos_d, best_d, res.value, res.status});
    end
  end

  assign m_axis_tvalid = mvalid_q;
  assign m_axis_tdata  = mdata_q;

endmodule

// ----- src/dcrc_checker.sv -----
module dcrc_checker
  import dcrc_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_tvalid_i,
  input logic                s_tready_i,
  input logic                m_tvalid_i,
  input logic                m_tready_i,
  input logic [OutDataW-1:0] m_tdata_i
);

  logic [1:0]        st;
  logic [WordW-1:0]  conv;
  logic [CountW-1:0] pos;
  logic [CountW-1:0] cnt;

  assign st   = m_tdata_i[1:0];
  assign conv = m_tdata_i[2 +: WordW];
  assign pos  = m_tdata_i[2 + 2 * WordW +: CountW];
  assign cnt  = m_tdata_i[2 + 2 * WordW + CountW +: CountW];

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && !m_tready_i |=> m_tvalid_i && $stable(m_tdata_i))
    else $error("stalled result changed");

  // one item at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_tvalid_i && s_tready_i |=> !s_tready_i)
    else $error("item accepted while busy");

  // status codes and zero value on error
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i |-> ((st == ST_OK) || (st == ST_BAD_BASE) || (st == ST_BAD_DIGIT))
      && ((st == ST_OK) || (conv == '0)))
    else $error("bad status or nonzero value on error");

  // position of the largest value tracks the count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i |-> (pos <= cnt) && ((pos == '0) == (cnt == '0)))
    else $error("largest position inconsistent with item count");

endmodule

bind decimal_coded_radix_converter dcrc_checker u_dcrc_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .s_tvalid_i (s_axis_tvalid),
  .s_tready_i (s_axis_tready),
  .m_tvalid_i (m_axis_tvalid),
  .m_tready_i (m_axis_tready),
  .m_tdata_i  (m_axis_tdata)
);

// ----- sim/decimal_coded_radix_converter_test.sv -----
`timescale 1ns / 1ps

module decimal_coded_radix_converter_test;
  import dcrc_pkg::*;

  // one result as it leaves the converter
  typedef struct packed {
    dcrc_status_e      status;
    logic [WordW-1:0]  value;
    logic [WordW-1:0]  largest;
    logic [CountW-1:0] position;
    logic [CountW-1:0] count;
  } conv_result_t;

  // one directed item, with a hand-written result where it is obvious
  typedef struct {
    logic [WordW-1:0]  number;
    logic [RadixW-1:0] radix;
    bit                typed;
    conv_result_t      want;
  } stim_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;   // coded_number, radix
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;        // status, converted_value,
                                            // largest_value, largest_position,
                                            // items_accepted

  decimal_coded_radix_converter uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // predicted converter state
  logic [WordW-1:0]  top_value = '0;
  logic [CountW-1:0] top_position = '0;
  logic [CountW-1:0] ok_count = '0;

  conv_result_t pending_results [$];
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int items_sent = 0;
  int items_rejected = 0;
  int results_checked = 0;
  int mismatches = 0;

  // directed items: bad bases, bad digits, extremes, ties
  stim_row_t directed_rows [25] = '{
    '{32'd0,           4'd0,  1'b1, '{ST_BAD_BASE,  32'd0, 32'd0, 16'd0, 16'd0}},
    '{32'd5,           4'd15, 1'b1, '{ST_BAD_BASE,  32'd0, 32'd0, 16'd0, 16'd0}},
    '{32'h8000_0000,   4'd1,  1'b1, '{ST_BAD_BASE,  32'd0, 32'd0, 16'd0, 16'd0}},
    '{32'd7,           4'd10, 1'b1, '{ST_BAD_BASE,  32'd0, 32'd0, 16'd0, 16'd0}},
    '{32'd2,           4'd2,  1'b1, '{ST_BAD_DIGIT, 32'd0, 32'd0, 16'd0, 16'd0}},
    '{32'd0,           4'd2,  1'b1, '{ST_OK,        32'd0, 32'd0, 16'd1, 16'd1}},
    '{32'hFFFF_FFFF,   4'd2,  1'b1, '{ST_OK, 32'hFFFF_FFFF, 32'd0, 16'd1, 16'd2}},
    '{32'h8000_0000,   4'd9,  1'b1,
      '{ST_OK, -32'sd841031063, 32'd0, 16'd1, 16'd3}},
    '{32'h8000_0000,   4'd8,  1'b1, '{ST_BAD_DIGIT, 32'd0, 32'd0, 16'd1, 16'd3}},
    '{32'h7FFF_FFFF,   4'd8,  1'b1, '{ST_BAD_DIGIT, 32'd0, 32'd0, 16'd1, 16'd3}},
    '{32'd10,          4'd2,  1'b1, '{ST_OK,        32'd2, 32'd2, 16'd4, 16'd4}},
    '{32'd10,          4'd2,  1'b1, '{ST_OK,        32'd2, 32'd2, 16'd4, 16'd5}},
    '{32'd1111111111,  4'd2,  1'b0, '0},
    '{-32'sd1111111111, 4'd2, 1'b0, '0},
    '{32'd876543210,   4'd9,  1'b0, '0},
    '{32'd12345670,    4'd8,  1'b0, '0},
    '{-32'sd7654321,   4'd8,  1'b0, '0},
    '{32'd222,         4'd3,  1'b0, '0},
    '{32'd9,           4'd9,  1'b0, '0},
    '{32'd91,          4'd9,  1'b0, '0},
    '{32'd19,          4'd9,  1'b0, '0},
    '{32'd1000000000,  4'd2,  1'b0, '0},
    '{-32'sd1000000000, 4'd2, 1'b0, '0},
    '{32'd888888888,   4'd9,  1'b0, '0},
    '{32'd8,           4'd9,  1'b0, '0}
  };

  // clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #50_000_000;
    $display("timeout at %0t with %0d results outstanding", $time, pending_results.size());
    $display("status: fail");
    $finish;
  end

  // radix conversion and running maximum, updates the predicted state
  function automatic conv_result_t convert_coded(input logic [WordW-1:0] number,
                                                 input logic [RadixW-1:0] radix);
    conv_result_t res;
    logic [WordW-1:0] rest;
    logic [63:0] acc;
    logic [63:0] weight;
    logic [DigitW-1:0] digit;
    logic neg;
    int n;
    res = '0;
    res.status = ST_OK;
    if (radix < RadixMin || radix > RadixMax) begin
      res.status = ST_BAD_BASE;
    end else begin
      neg = number[WordW-1];
      rest = neg ? -number : number;
      acc = '0;
      weight = 64'd1;
      for (n = 0; n < MaxDigits && rest != '0 && res.status == ST_OK; n++) begin
        digit = DigitW'(rest % 10);
        rest = rest / 10;
        if (digit >= radix) begin
          res.status = ST_BAD_DIGIT;
        end else begin
          acc = acc + 64'(digit) * weight;
          weight = weight * 64'(radix);
        end
      end
      if (res.status == ST_OK) res.value = neg ? -acc[WordW-1:0] : acc[WordW-1:0];
    end
    // only accepted items touch the count and the maximum
    if (res.status == ST_OK) begin
      if (ok_count != CountTop) ok_count = ok_count + 1'b1;
      if (top_position == '0 || $signed(res.value) > $signed(top_value)) begin
        top_value = res.value;
        top_position = ok_count;
      end
    end else begin
      res.value = '0;
    end
    res.largest = top_value;
    res.position = top_position;
    res.count = ok_count;
    return res;
  endfunction

  // number built from random digits below the radix, one bad digit on request
  function automatic logic [WordW-1:0] make_coded(input logic [RadixW-1:0] radix,
                                                  input int ndig, input bit neg,
                                                  input int bad_at);
    logic [63:0] mag;
    int k;
    mag = '0;
    for (k = ndig - 1; k >= 0; k--) begin
      if (k == bad_at) mag = mag * 10 + 64'($urandom_range(9, radix));
      else mag = mag * 10 + 64'($urandom_range(radix - 1));
    end
    // keep inside the signed word and below the largest positive item
    if ((!neg && mag >= 64'd2147483647) || (neg && mag > 64'd2147483648))
      mag = mag % 64'd1000000000;
    return neg ? -mag[WordW-1:0] : mag[WordW-1:0];
  endfunction

  // present one item, wait for its accept and record the expected result
  task automatic send_item(input logic [WordW-1:0] number, input logic [RadixW-1:0] radix,
                           input bit typed, input conv_result_t want);
    conv_result_t pred;
    int gap;
    gap = 0;
    while (gap < 20 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= InDataW'({radix, number});
    do @(posedge clk_i); while (!s_axis_tready);
    pred = convert_coded(number, radix);
    pending_results.push_back(typed ? want : pred);
    items_sent++;
    if (pred.status != ST_OK) items_rejected++;
  endtask

  // mostly well-formed items, then bad digits, bad bases and raw noise
  task automatic send_random_item();
    logic [RadixW-1:0] radix;
    logic [WordW-1:0] number;
    int pick;
    int ndig;
    int sel;
    pick = $urandom_range(99);
    radix = RadixW'($urandom_range(9, 2));
    ndig = $urandom_range(MaxDigits, 1);
    if (pick < 70) begin
      number = make_coded(radix, ndig, $urandom_range(1), -1);
    end else if (pick < 82) begin
      number = make_coded(radix, ndig, $urandom_range(1), $urandom_range(ndig - 1));
    end else if (pick < 92) begin
      sel = $urandom_range(7);
      radix = (sel < 2) ? RadixW'(sel) : RadixW'(sel + 8);
      number = $urandom;
    end else begin
      radix = RadixW'($urandom_range(15));
      number = $urandom;
    end
    send_item(number, radix, 1'b0, '0);
  endtask

  // receiver stalls
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // compare each result with the oldest expectation
  always @(posedge clk_i) begin : result_check
    conv_result_t got;
    conv_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.status = dcrc_status_e'(m_axis_tdata[1:0]);
      got.value = m_axis_tdata[2 +: WordW];
      got.largest = m_axis_tdata[2 + WordW +: WordW];
      got.position = m_axis_tdata[2 + 2 * WordW +: CountW];
      got.count = m_axis_tdata[2 + 2 * WordW + CountW +: CountW];
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 20)
          $display("%0t: unexpected result, got status=%0d value=%0d", $time,
                   got.status, $signed(got.value));
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 20) begin
            $display("%0t: mismatch expected st=%0d val=%0d max=%0d pos=%0d cnt=%0d",
                     $time, want.status, $signed(want.value), $signed(want.largest),
                     want.position, want.count);
            $display("%0t:          got      st=%0d val=%0d max=%0d pos=%0d cnt=%0d",
                     $time, got.status, $signed(got.value), $signed(got.largest),
                     got.position, got.count);
          end
        end
      end
    end
  end

  // stimulus
  initial begin
    int i;
    int ph;
    int w;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed items
    for (i = 0; i < 25; i++)
      send_item(directed_rows[i].number, directed_rows[i].radix, directed_rows[i].typed,
                directed_rows[i].want);

    // random items across idle and stall patterns
    for (ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1 || ph == 0) ? ((ph == 1) ? 57 : 0) : ((ph == 3) ? 7 : 0);
      recv_stall_pct = (ph == 2) ? 57 : ((ph == 3) ? 7 : 0);
      for (i = 0; i < 225; i++) send_random_item();
    end

    // late items: the largest positive base-9 item, then a tie with it
    send_idle_pct = 57;
    recv_stall_pct = 57;
    for (i = 0; i < 20; i++) send_random_item();
    send_item(32'h7FFF_FFFF, 4'd9, 1'b0, '0);
    send_item(32'h7FFF_FFFF, 4'd9, 1'b0, '0);
    for (i = 0; i < 10; i++) send_random_item();
    s_axis_tvalid <= 1'b0;

    // drain
    for (w = 0; w < 100000 && pending_results.size() != 0; w++) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("%0d items sent (%0d rejected), %0d results compared, %0d mismatches",
             items_sent, items_rejected, results_checked, mismatches);
    $display("item count reached %0d; largest value %0d held at position %0d",
             ok_count, $signed(top_value), top_position);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d results never arrived", pending_results.size());
      $display("status: fail");
    end
    $finish;
  end

endmodule
